// ----- src/assert_macros.svh -----
// assertion macros included by the blitter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- src/ramb_pkg.sv -----
// constants, types and tables for the rotated alpha mask blitter
package ramb_pkg;

    localparam int unsigned MASK_DEPTH    = 4096;
    localparam int unsigned MASK_AW       = $clog2(MASK_DEPTH);
    localparam int unsigned MAX_ICON_SIDE = 64;
    localparam int unsigned FRAME_LIMIT   = 2048;
    localparam int unsigned R5_MAX        = 31;
    localparam int unsigned G6_MAX        = 63;
    localparam int unsigned CH_MAX        = 255;

    // input commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_FOREGROUND = 3'd0;
    localparam logic [2:0] REG_ROTATION   = 3'd1;
    localparam logic [2:0] REG_ICON_W     = 3'd2;
    localparam logic [2:0] REG_ICON_H     = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X   = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd5;
    localparam logic [2:0] REG_FRAME_W    = 3'd6;
    localparam logic [2:0] REG_FRAME_H    = 3'd7;

    typedef logic [7:0] exp5_tab_t [32];
    typedef logic [7:0] exp6_tab_t [64];

    // channel expansion tables, built at elaboration
    function automatic exp5_tab_t build_exp5();
        exp5_tab_t tab;
        for (int i = 0; i < 32; i++)
        begin
            tab[i] = 8'((i * CH_MAX) / R5_MAX);
        end
        return tab;
    endfunction

    function automatic exp6_tab_t build_exp6();
        exp6_tab_t tab;
        for (int i = 0; i < 64; i++)
        begin
            tab[i] = 8'((i * CH_MAX) / G6_MAX);
        end
        return tab;
    endfunction

    localparam exp5_tab_t EXP5_TAB = build_exp5();
    localparam exp6_tab_t EXP6_TAB = build_exp6();

    // request in flight after the address stage
    typedef struct packed {
        logic        hit;
        logic [10:0] px;
        logic [10:0] py;
        logic [7:0]  bg_r;
        logic [7:0]  bg_g;
        logic [7:0]  bg_b;
    } s1_t;

    // request in flight after the multiply stage
    typedef struct packed {
        logic        write;
        logic [10:0] px;
        logic [10:0] py;
        logic [15:0] sum_r;
        logic [15:0] sum_g;
        logic [15:0] sum_b;
    } s2_t;

endpackage

// ----- src/rotated_alpha_mask_blit_unit.sv -----
// top level of the rotated alpha mask blitter
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | command, mask_index, mask_value, offset_*, bg_*
//  out     | out_valid / out_ready  | write_pixel, pixel_x, pixel_y, out_*
//  cfg     | cfg_we                 | cfg_index, cfg_data
//
// one request per clock unless stalled; a request passes through address and mask read,
// multiply, and divide by 255 into the output register
// the mask ram has one write and one read port and holds no reset state
// all stages move together; they stall only while the output holds a result
// that is not taken, and in_ready drops for exactly those cycles
`include "assert_macros.svh"

module rotated_alpha_mask_blit_unit
    import ramb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [11:0] mask_index,
    input  logic [7:0]  mask_value,
    input  logic [5:0]  offset_col,
    input  logic [5:0]  offset_row,
    input  logic [7:0]  bg_red,
    input  logic [7:0]  bg_green,
    input  logic [7:0]  bg_blue,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_pixel,
    output logic [10:0] pixel_x,
    output logic [10:0] pixel_y,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue
);

    // configuration registers
    logic [15:0] fg_reg;
    logic [1:0]  rotation_reg;
    logic [6:0]  icon_w_reg;
    logic [6:0]  icon_h_reg;
    logic [11:0] origin_x_reg;
    logic [11:0] origin_y_reg;
    logic [11:0] frame_w_reg;
    logic [11:0] frame_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg       <= 16'hFFFF;
            rotation_reg <= ROT_0;
            icon_w_reg   <= 7'd16;
            icon_h_reg   <= 7'd16;
            origin_x_reg <= 12'd0;
            origin_y_reg <= 12'd0;
            frame_w_reg  <= 12'd320;
            frame_h_reg  <= 12'd240;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FOREGROUND: fg_reg       <= cfg_data;
                REG_ROTATION:   rotation_reg <= cfg_data[1:0];
                REG_ICON_W:     icon_w_reg   <= cfg_data[6:0];
                REG_ICON_H:     icon_h_reg   <= cfg_data[6:0];
                REG_ORIGIN_X:   origin_x_reg <= cfg_data[11:0];
                REG_ORIGIN_Y:   origin_y_reg <= cfg_data[11:0];
                REG_FRAME_W:    frame_w_reg  <= cfg_data[11:0];
                REG_FRAME_H:    frame_h_reg  <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic advance;
    logic in_fire;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign in_fire  = in_valid && advance;

    // address stage: rotation, clipping and mask index
    logic [6:0]  w, h, dw, dh;
    logic [11:0] fw, fh;
    logic [6:0]  col7, row7, sx, sy;
    logic [13:0] idx;
    logic        in_icon, in_frame, idx_ok, pix_hit;
    logic signed [12:0] px, py;

    always_comb
    begin
        w    = (icon_w_reg > 7'(MAX_ICON_SIDE)) ? 7'(MAX_ICON_SIDE) : icon_w_reg;
        h    = (icon_h_reg > 7'(MAX_ICON_SIDE)) ? 7'(MAX_ICON_SIDE) : icon_h_reg;
        dw   = rotation_reg[0] ? h : w;
        dh   = rotation_reg[0] ? w : h;
        fw   = (frame_w_reg > 12'(FRAME_LIMIT)) ? 12'(FRAME_LIMIT) : frame_w_reg;
        fh   = (frame_h_reg > 12'(FRAME_LIMIT)) ? 12'(FRAME_LIMIT) : frame_h_reg;
        col7 = {1'b0, offset_col};
        row7 = {1'b0, offset_row};

        in_icon = (col7 < dw) && (row7 < dh);

        px = $signed({origin_x_reg[11], origin_x_reg}) + $signed({7'b0, offset_col});
        py = $signed({origin_y_reg[11], origin_y_reg}) + $signed({7'b0, offset_row});
        in_frame = !px[12] && !py[12] && (px[11:0] < fw) && (py[11:0] < fh);

        case (rotation_reg)
            ROT_90:
            begin
                sx = row7;
                sy = h - 7'd1 - col7;
            end
            ROT_180:
            begin
                sx = w - 7'd1 - col7;
                sy = h - 7'd1 - row7;
            end
            ROT_270:
            begin
                sx = w - 7'd1 - row7;
                sy = col7;
            end
            default:
            begin
                sx = col7;
                sy = row7;
            end
        endcase

        idx     = 14'(sy) * 14'(w) + 14'(sx);
        idx_ok  = idx < 14'(MASK_DEPTH);
        pix_hit = (command == CMD_PIXEL) && in_icon && in_frame && idx_ok;
    end

    // mask store
    logic                ram_we, ram_re;
    logic [MASK_AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]          ram_rdata;

    assign ram_we    = in_fire && (command == CMD_LOAD)
                       && (13'(mask_index) < 13'(MASK_DEPTH));
    assign ram_waddr = mask_index[MASK_AW-1:0];
    assign ram_re    = in_fire && pix_hit;
    assign ram_raddr = idx[MASK_AW-1:0];

    ramb_ram #(
        .WIDTH (8),
        .DEPTH (MASK_DEPTH)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (mask_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    s1_t s1_reg, s1_next;

    always_comb
    begin
        s1_next.hit  = pix_hit;
        s1_next.px   = px[10:0];
        s1_next.py   = py[10:0];
        s1_next.bg_r = bg_red;
        s1_next.bg_g = bg_green;
        s1_next.bg_b = bg_blue;
    end

    // multiply stage; ram data belongs to the request in s1 since reads only
    // happen when that request is taken and nothing moves until it advances
    logic [7:0] fr, fgc, fb, inv_a;
    s2_t        s2_reg, s2_next;

    always_comb
    begin
        fr    = EXP5_TAB[fg_reg[15:11]];
        fgc   = EXP6_TAB[fg_reg[10:5]];
        fb    = EXP5_TAB[fg_reg[4:0]];
        inv_a = 8'(CH_MAX) - ram_rdata;

        s2_next.write = s1_reg.hit && (ram_rdata != 8'd0);
        s2_next.px    = s1_reg.px;
        s2_next.py    = s1_reg.py;
        s2_next.sum_r = 16'(fr) * 16'(ram_rdata) + 16'(s1_reg.bg_r) * 16'(inv_a);
        s2_next.sum_g = 16'(fgc) * 16'(ram_rdata) + 16'(s1_reg.bg_g) * 16'(inv_a);
        s2_next.sum_b = 16'(fb) * 16'(ram_rdata) + 16'(s1_reg.bg_b) * 16'(inv_a);
    end

    // exact x / 255 for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] t;
        t = x + {8'd0, x[15:8]} + 16'd1;
        return t[15:8];
    endfunction

    logic        write_reg;
    logic [10:0] pixel_x_reg, pixel_y_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg      <= s1_next;
            s2_reg      <= s2_next;
            write_reg   <= s2_reg.write;
            pixel_x_reg <= s2_reg.write ? s2_reg.px : 11'd0;
            pixel_y_reg <= s2_reg.write ? s2_reg.py : 11'd0;
            red_reg     <= s2_reg.write ? div255(s2_reg.sum_r) : 8'd0;
            green_reg   <= s2_reg.write ? div255(s2_reg.sum_g) : 8'd0;
            blue_reg    <= s2_reg.write ? div255(s2_reg.sum_b) : 8'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_pixel = write_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign out_red     = red_reg;
    assign out_green   = green_reg;
    assign out_blue    = blue_reg;

    `ASSERT_IMP(a_ram_port_excl, ram_we, !ram_re)
    `ASSERT_NXT(a_load_no_hit, in_fire && (command == CMD_LOAD), !s1_reg.hit)
    `ASSERT_IMP(a_idle_zero, out_valid && !write_pixel, (pixel_x == 11'd0) && (pixel_y == 11'd0) && (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0))

endmodule

// ----- src/ramb_ram.sv -----
// generic single write port, single read port ram with registered read
module ramb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
